/* design/rpf_pkg.sv */
`timescale 1ns / 1ps

package rpf_pkg;

  localparam int PALETTE_DEPTH = 8;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int COLOR_W       = 24;
  localparam int LEVEL_W       = 8;
  localparam int DUTY_W        = 10;
  localparam int CNT_W         = 4;
  localparam int IVL_W         = 16;
  localparam int CD_W          = 23;
  localparam int CYCLE_SCALE   = 100;
  localparam int CFG_AW        = 2;
  localparam int CFG_DW        = 16;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    RUN_IDLE  = 2'd0,
    RUN_FADE  = 2'd1,
    RUN_CYCLE = 2'd2
  } run_t;

  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_FADE   = 2'd1;
  localparam logic [1:0] MODE_CYCLE  = 2'd2;

  localparam logic [CFG_AW-1:0] REG_MODE     = 2'd0;
  localparam logic [CFG_AW-1:0] REG_COUNT    = 2'd1;
  localparam logic [CFG_AW-1:0] REG_INTERVAL = 2'd2;

  typedef struct packed {
    run_t               run;
    logic [CNT_W-1:0]   pos;
    logic               first;
    logic [COLOR_W-1:0] cur;
    logic [COLOR_W-1:0] tgt;
    logic [CD_W-1:0]    cd;
  } state_t;

  typedef struct packed {
    logic emit;
    logic pal_we;
  } step_ctl_t;

  typedef struct packed {
    logic [PAL_AW-1:0] a;
    logic [PAL_AW-1:0] b;
  } rd_addr_t;

  // position used by a cycling step, wrapped when at or past the count
  function automatic logic [CNT_W-1:0] cycle_pos(input logic [CNT_W-1:0] pos,
                                                 input logic [CNT_W-1:0] cnt);
    return (pos >= cnt) ? '0 : pos;
  endfunction

  // fade: the pair after this one is the last entry and entry zero
  function automatic logic fade_last(input logic [CNT_W-1:0] pos,
                                     input logic [CNT_W-1:0] cnt);
    logic [CNT_W:0] nx;
    nx = {1'b0, pos} + 1'b1;
    return nx == ({1'b0, cnt} - 1'b1);
  endfunction

  function automatic logic [CNT_W-1:0] fade_pos(input logic [CNT_W-1:0] pos,
                                                input logic [CNT_W-1:0] cnt);
    logic [CNT_W:0] nx;
    nx = {1'b0, pos} + 1'b1;
    if (fade_last(pos, cnt)) begin
      return nx[CNT_W-1:0];
    end else if (nx >= {1'b0, cnt}) begin
      return '0;
    end else begin
      return nx[CNT_W-1:0];
    end
  endfunction

  // palette read addresses needed by the next step from this state
  function automatic rd_addr_t pal_rd_addr(input run_t run,
                                           input logic [CNT_W-1:0] pos,
                                           input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] fp;
    logic [CNT_W-1:0] cp;
    rd_addr_t ra;
    fp = fade_pos(pos, cnt);
    cp = cycle_pos(pos, cnt);
    if (run == RUN_FADE) begin
      ra.a = fp[PAL_AW-1:0];
      ra.b = fade_last(pos, cnt) ? '0 : PAL_AW'(fp[PAL_AW-1:0] + 1'b1);
    end else begin
      ra.a = cp[PAL_AW-1:0];
      ra.b = '0;
    end
    return ra;
  endfunction

  function automatic logic [LEVEL_W-1:0] approach(input logic [LEVEL_W-1:0] c,
                                                  input logic [LEVEL_W-1:0] t);
    if (c > t) begin
      return c - 1'b1;
    end else if (c < t) begin
      return c + 1'b1;
    end else begin
      return c;
    end
  endfunction

  function automatic logic [DUTY_W-1:0] duty(input logic [LEVEL_W-1:0] lvl);
    return {lvl, 2'b00};
  endfunction

endpackage

/* design/rpf_ram.sv */
`timescale 1ns / 1ps

module rpf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read during write returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* design/rpf_step.sv */
`timescale 1ns / 1ps

module rpf_step (
  input  rpf_pkg::state_t                     st,
  input  logic [1:0]                          cmd,
  input  logic [1:0]                          mode_select,
  input  logic [rpf_pkg::CNT_W-1:0]           color_count,
  input  logic [rpf_pkg::IVL_W-1:0]           interval_ms,
  input  logic [rpf_pkg::COLOR_W-1:0]         pal0,
  input  logic [rpf_pkg::COLOR_W-1:0]         pal1,
  input  logic [rpf_pkg::COLOR_W-1:0]         rd_a,
  input  logic [rpf_pkg::COLOR_W-1:0]         rd_b,
  output rpf_pkg::state_t                     st_next,
  output rpf_pkg::step_ctl_t                  ctl,
  output logic [rpf_pkg::COLOR_W-1:0]         emit_color
);

  logic [rpf_pkg::COLOR_W-1:0] cur0;
  logic [rpf_pkg::COLOR_W-1:0] tgt0;
  logic [rpf_pkg::COLOR_W-1:0] stepped;
  logic [rpf_pkg::CD_W-1:0]    period;
  logic [rpf_pkg::CNT_W-1:0]   cyc_pos;

  // the first fade step starts from the first two entries
  assign cur0 = st.first ? pal0 : st.cur;
  assign tgt0 = st.first ? pal1 : st.tgt;

  assign stepped = {rpf_pkg::approach(cur0[23:16], tgt0[23:16]),
                    rpf_pkg::approach(cur0[15:8], tgt0[15:8]),
                    rpf_pkg::approach(cur0[7:0], tgt0[7:0])};

  assign period = (st.run == rpf_pkg::RUN_CYCLE)
                ? rpf_pkg::CD_W'(interval_ms) * rpf_pkg::CD_W'(rpf_pkg::CYCLE_SCALE)
                : rpf_pkg::CD_W'(interval_ms);

  assign cyc_pos = rpf_pkg::cycle_pos(st.pos, color_count);

  always_comb begin
    st_next    = st;
    ctl.emit   = 1'b0;
    ctl.pal_we = 1'b0;
    emit_color = '0;
    unique case (cmd)
      rpf_pkg::CMD_WRITE: begin
        ctl.pal_we = 1'b1;
      end
      rpf_pkg::CMD_START: begin
        st_next.run   = rpf_pkg::RUN_IDLE;
        st_next.pos   = '0;
        st_next.cd    = '0;
        st_next.first = 1'b1;
        if (mode_select == rpf_pkg::MODE_SINGLE) begin
          ctl.emit   = 1'b1;
          emit_color = pal0;
        end else if ((mode_select == rpf_pkg::MODE_FADE ||
                      mode_select == rpf_pkg::MODE_CYCLE) && color_count > 4'd1) begin
          st_next.run = rpf_pkg::run_t'(mode_select);
        end
      end
      rpf_pkg::CMD_TICK: begin
        if (st.run != rpf_pkg::RUN_IDLE) begin
          if (st.cd != '0) begin
            st_next.cd = st.cd - 1'b1;
          end else begin
            st_next.cd = (period == '0) ? '0 : period - 1'b1;
            if (st.run == rpf_pkg::RUN_FADE) begin
              st_next.first = 1'b0;
              if (cur0 != tgt0) begin
                st_next.cur = stepped;
                st_next.tgt = tgt0;
                ctl.emit    = 1'b1;
                emit_color  = stepped;
              end else begin
                // arrived: move on to the next pair, nothing shown
                st_next.pos = rpf_pkg::fade_pos(st.pos, color_count);
                st_next.cur = rd_a;
                st_next.tgt = rd_b;
              end
            end else begin
              st_next.pos = cyc_pos + 1'b1;
              ctl.emit    = 1'b1;
              emit_color  = rd_a;
            end
          end
        end
      end
      default: ;
    endcase
  end

endmodule

/* design/rgb_palette_fade_sequencer_core.sv */
`timescale 1ns / 1ps

// RGB palette fade sequencer. Takes one word per clock on the s_ side: ticks,
// palette writes and mode starts. A word is held in the input register and is
// worked from there, and its result is registered in the output register on
// the m_ side; the input register doubles as a skid stage, so a word is still
// taken while a result waits in the output register, and the
// input stalls only when both are full. The palette is a small two-read-port
// RAM with registered read; it is read every cycle at the addresses the next
// step will need, computed from the position that the word now in work
// leaves behind, with a write of that same word forwarded. Entries 0 and 1
// are also kept in flops for single-color starts and the first fade step.
// Ticks are counted down from interval_ms (times 100 in cycling mode) per step.

module rgb_palette_fade_sequencer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // entry_index, red_in, green_in, blue_in
  input  logic [1:0]                    s_tuser,   // cmd
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,   // red_duty, green_duty, blue_duty
  input  logic                          cfg_we,
  input  logic [rpf_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [rpf_pkg::CFG_DW-1:0]    cfg_data
);

  logic [1:0]                  mode_select;
  logic [rpf_pkg::CNT_W-1:0]   color_count;
  logic [rpf_pkg::IVL_W-1:0]   interval_ms;
  logic [rpf_pkg::CNT_W-1:0]   cnt_after;

  logic                        p_valid;
  logic [1:0]                  p_cmd;
  logic [rpf_pkg::PAL_AW-1:0]  p_idx;
  logic [rpf_pkg::COLOR_W-1:0] p_rgb;
  logic                        p_fire;
  logic                        s_accept;

  rpf_pkg::state_t             st;
  rpf_pkg::state_t             st_next;
  rpf_pkg::state_t             st_after;
  rpf_pkg::step_ctl_t          ctl;
  logic [rpf_pkg::COLOR_W-1:0] emit_color;

  logic [rpf_pkg::COLOR_W-1:0] pal0;
  logic [rpf_pkg::COLOR_W-1:0] pal1;
  rpf_pkg::rd_addr_t           raddr;
  logic [rpf_pkg::COLOR_W-1:0] ram_a;
  logic [rpf_pkg::COLOR_W-1:0] ram_b;
  logic [rpf_pkg::COLOR_W-1:0] rd_a;
  logic [rpf_pkg::COLOR_W-1:0] rd_b;
  logic                        fwd_a;
  logic                        fwd_b;
  logic [rpf_pkg::COLOR_W-1:0] fwd_data;
  logic                        pal_write;

  assign p_fire   = p_valid && (!m_tvalid || m_tready);
  assign s_tready = !p_valid || p_fire;
  assign s_accept = s_tvalid && s_tready;

  assign pal_write = p_fire && ctl.pal_we;

  // state and count as they stand after this edge
  assign st_after  = p_fire ? st_next : st;
  assign cnt_after = (cfg_we && cfg_index == rpf_pkg::REG_COUNT)
                   ? cfg_data[rpf_pkg::CNT_W-1:0] : color_count;
  assign raddr     = rpf_pkg::pal_rd_addr(st_after.run, st_after.pos, cnt_after);

  assign rd_a = fwd_a ? fwd_data : ram_a;
  assign rd_b = fwd_b ? fwd_data : ram_b;

  rpf_ram #(
    .WIDTH (rpf_pkg::COLOR_W),
    .DEPTH (rpf_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .we      (pal_write),
    .waddr   (p_idx),
    .wdata   (p_rgb),
    .raddr_a (raddr.a),
    .raddr_b (raddr.b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  rpf_step u_step (
    .st          (st),
    .cmd         (p_cmd),
    .mode_select (mode_select),
    .color_count (color_count),
    .interval_ms (interval_ms),
    .pal0        (pal0),
    .pal1        (pal1),
    .rd_a        (rd_a),
    .rd_b        (rd_b),
    .st_next     (st_next),
    .ctl         (ctl),
    .emit_color  (emit_color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_select <= '0;
      color_count <= '0;
      interval_ms <= '0;
      p_valid     <= 1'b0;
      m_tvalid    <= 1'b0;
      fwd_a       <= 1'b0;
      fwd_b       <= 1'b0;
      st.run      <= rpf_pkg::RUN_IDLE;
      st.pos      <= '0;
      st.first    <= 1'b1;
      st.cur      <= '0;
      st.tgt      <= '0;
      st.cd       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rpf_pkg::REG_MODE:     mode_select <= cfg_data[1:0];
          rpf_pkg::REG_COUNT:    color_count <= cfg_data[rpf_pkg::CNT_W-1:0];
          rpf_pkg::REG_INTERVAL: interval_ms <= cfg_data;
          default: ;
        endcase
      end
      if (s_tready) begin
        p_valid <= s_tvalid;
      end
      if (p_fire) begin
        st <= st_next;
      end
      if (p_fire && ctl.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // a palette write lands in the same edge as the read it must feed
      fwd_a <= pal_write && (p_idx == raddr.a);
      fwd_b <= pal_write && (p_idx == raddr.b);
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      p_cmd <= s_tuser;
      p_idx <= s_tdata[2:0];
      p_rgb <= {s_tdata[10:3], s_tdata[18:11], s_tdata[26:19]};
    end
    if (pal_write) begin
      fwd_data <= p_rgb;
      if (p_idx == rpf_pkg::PAL_AW'(0)) begin
        pal0 <= p_rgb;
      end
      if (p_idx == rpf_pkg::PAL_AW'(1)) begin
        pal1 <= p_rgb;
      end
    end
    if (p_fire && ctl.emit) begin
      m_tdata <= {2'b00,
                  rpf_pkg::duty(emit_color[7:0]),
                  rpf_pkg::duty(emit_color[15:8]),
                  rpf_pkg::duty(emit_color[23:16])};
    end
  end

endmodule

/* design/rpf_chk.sv */
`timescale 1ns / 1ps

module rpf_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // a held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // duties are levels times four, pad bits stay clear
  a_duty_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] == 2'b00 && m_tdata[11:10] == 2'b00 &&
                 m_tdata[21:20] == 2'b00 && m_tdata[31:30] == 2'b00)
    else $error("duty word malformed");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with output free");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result after reset");

endmodule

bind rgb_palette_fade_sequencer_core rpf_chk u_rpf_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
